/* rtl/core/mcrf_pkg.sv */
`timescale 1ns / 1ps

package mcrf_pkg;

   localparam int unsigned ID_W    = 32;
   localparam int unsigned FLAG_W  = 32;
   localparam int unsigned METRIC_W = 32;
   localparam int unsigned STAMP_W = 64;
   localparam int unsigned COUNT_W = 7;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [ID_W-1:0]     node_id;
      logic [FLAG_W-1:0]   flags;
      logic [METRIC_W-1:0] complexity;
      logic [METRIC_W-1:0] performance;
      logic [STAMP_W-1:0]  stamp;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    match_id;
      logic               match_valid;
      logic               status;
      logic [COUNT_W-1:0] match_count;
      logic               last;
   } rsp_type;

   // One stored table entry.
   typedef struct packed {
      logic [ID_W-1:0]     node_id;
      logic [FLAG_W-1:0]   flags;
      logic [METRIC_W-1:0] complexity;
      logic [METRIC_W-1:0] performance;
      logic [STAMP_W-1:0]  stamp;
   } rec_type;

endpackage

/* rtl/core/multi_criteria_record_filter.sv */
`timescale 1ns / 1ps
// An insert transfer's result is registered and offered in the cycle after it is accepted.
// Inserts can be accepted every cycle while the result side keeps up.
// A search scans all N stored records: the table memory has one read port, so the scan
// reads one record per cycle unless a busy output stalls it, and ends with the final result.
// Reset clears the record count, the sequencer and the output valid; the table itself is not
// cleared, since only entries below the record count are ever read.
module multi_criteria_record_filter #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcrf_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcrf_pkg::rsp_type rsp_payload
);
   import mcrf_pkg::*;

   // Address bits for the table, and a count wide enough to hold CAPACITY itself.
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // The record table: one write port for inserts, one registered read port for the scan.
   rec_type rec_mem [CAPACITY];
   rec_type rd_data_ff;

   logic [1:0]      state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   addr_ff, addr_in;
   logic            rd_vld_ff, rd_vld_in;
   req_type         crit_ff, crit_in;

   // The most recent match is held back one step, because only the end of the scan
   // tells whether it is the final result of the search.
   logic            hold_vld_ff, hold_vld_in;
   logic [ID_W-1:0] hold_id_ff, hold_id_in;
   logic [CW-1:0]   match_cnt_ff, match_cnt_in;

   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            out_busy;
   logic            req_fire;
   logic            hit;
   logic            need_out;
   logic            advance;
   logic            consume;
   logic            rd_en;
   logic            mem_we;
   logic            push;
   rsp_type         push_data;

   mcrf_match u_match (
      .rec  (rd_data_ff),
      .crit (crit_ff),
      .hit  (hit)
   );

   // The output register can load when it is empty or being drained this cycle.
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !out_busy;
   assign req_fire  = req_valid && req_ready;

   // A new match while one is held sends the held one out; if the output register
   // is still occupied, the scan stalls with the read data kept in its register.
   assign need_out = rd_vld_ff && hit && hold_vld_ff;
   assign advance  = !(need_out && out_busy);
   assign consume  = (state_ff == ST_SCAN) && rd_vld_ff && advance;
   assign rd_en    = (state_ff == ST_SCAN) && (addr_ff < count_ff) && advance;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_vld_in    = rd_vld_ff;
      crit_in      = crit_ff;
      hold_vld_in  = hold_vld_ff;
      hold_id_in   = hold_id_ff;
      match_cnt_in = match_cnt_ff;
      mem_we       = 1'b0;
      push         = 1'b0;
      push_data    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.cmd == CMD_INSERT) begin
                  push             = 1'b1;
                  push_data.last   = 1'b1;
                  if (count_ff >= CW'(CAPACITY)) begin
                     push_data.status = STATUS_FULL;
                  end else begin
                     push_data.status = STATUS_OK;
                     mem_we           = 1'b1;
                     count_in         = count_ff + CW'(1);
                  end
               end else begin
                  crit_in      = req_payload;
                  addr_in      = '0;
                  hold_vld_in  = 1'b0;
                  match_cnt_in = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               addr_in = addr_ff + CW'(1);
            end
            if (rd_en) begin
               rd_vld_in = 1'b1;
            end else if (consume) begin
               rd_vld_in = 1'b0;
            end
            if (consume && hit) begin
               hold_vld_in  = 1'b1;
               hold_id_in   = rd_data_ff.node_id;
               match_cnt_in = match_cnt_ff + CW'(1);
               if (hold_vld_ff) begin
                  push                  = 1'b1;
                  push_data.match_id    = hold_id_ff;
                  push_data.match_valid = 1'b1;
                  push_data.status      = STATUS_OK;
                  push_data.match_count = COUNT_W'(match_cnt_ff);
                  push_data.last        = 1'b0;
               end
            end
            // Every record has been read and evaluated.
            if (!rd_vld_ff && (addr_ff == count_ff)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_busy) begin
               push             = 1'b1;
               push_data.status = STATUS_OK;
               push_data.last   = 1'b1;
               if (hold_vld_ff) begin
                  push_data.match_id    = hold_id_ff;
                  push_data.match_valid = 1'b1;
                  push_data.match_count = COUNT_W'(match_cnt_ff);
               end
               hold_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_in       = push ? push_data : rsp_ff;
   assign rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Table memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[count_ff[AW-1:0]] <= '{node_id:     req_payload.node_id,
                                        flags:       req_payload.flags,
                                        complexity:  req_payload.complexity,
                                        performance: req_payload.performance,
                                        stamp:       req_payload.stamp};
      end
      if (rd_en) begin
         rd_data_ff <= rec_mem[addr_ff[AW-1:0]];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan bookkeeping.
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      crit_ff      <= crit_in;
      hold_id_ff   <= hold_id_in;
      match_cnt_ff <= match_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/core/mcrf_match.sv */
`timescale 1ns / 1ps

module mcrf_match (
   input  mcrf_pkg::rec_type rec,
   input  mcrf_pkg::req_type crit,
   output logic              hit
);
   import mcrf_pkg::*;

   logic flag_ok;
   logic cx_ok;
   logic pf_ok;
   logic st_ok;

   // A zero mask accepts every record.
   assign flag_ok = (crit.flags == '0) || ((rec.flags & crit.flags) != '0);
   assign cx_ok   = rec.complexity  >= crit.complexity;
   assign pf_ok   = rec.performance >= crit.performance;
   assign st_ok   = rec.stamp       >= crit.stamp;
   assign hit     = flag_ok && cx_ok && pf_ok && st_ok;

endmodule
